@@ src/fpsa_pkg.sv @@
// Shared types and constants for the fit-policy segment allocator.
// No dependencies.
`default_nettype none
package fpsa_pkg;
	localparam int POOL_UNITS   = 1024;
	localparam int MAX_SEGMENTS = 16;
	localparam int ADDR_W = 10;
	localparam int LEN_W  = 11;
	localparam int END_W  = LEN_W + 1;
	localparam int IDX_W  = $clog2(MAX_SEGMENTS);
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Request actions
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Fit policy codes (anything else is first fit)
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	// Register address of fit_policy
	localparam logic [1:0] REG_FIT_POLICY = 2'd0;

	// One free segment as held in the table
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);
endpackage
`default_nettype wire

@@ src/fit_policy_segment_allocator.sv @@
// Top level of the fit-policy segment allocator.
// Depends on fpsa_pkg and fpsa_ram (free segment table).
//
// Usage:
//  Request channel: drive action, req_length, release_start and raise start;
//  the word is taken at a clock edge where start is high and busy is low.
//  Result channel: done pulses for one cycle with status and grant_start;
//  the receiver cannot stall, so the word must be captured in that cycle.
//  Config: APB write of fit_policy at address 0, only while idle; pready is
//  always high.
//  Operation: the free table sits in one RAM with a registered read.
//  A request scans the table once, decides in the apply state, and if a
//  segment is removed or inserted sweeps the entries above it one per
//  cycle. Zero-length requests and out-of-pool releases answer straight
//  from idle without a scan. One request at a time.
//  Reset: one cycle after reset writes the single pool-wide free segment;
//  busy is high during it.
`default_nettype none
module fit_policy_segment_allocator
	import fpsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [1:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              action,
	input  wire logic [LEN_W-1:0]  req_length,
	input  wire logic [ADDR_W-1:0] release_start,
	output logic                   done,
	output logic      [1:0]        status,
	output logic      [ADDR_W-1:0] grant_start
);
	typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_SCAN, ST_APPLY, ST_SWEEP} state_t;

	state_t            state_q;
	logic [1:0]        policy_q;
	logic [CNT_W-1:0]  count_q;
	logic              act_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] rs_q;
	logic [CNT_W-1:0]  scan_k_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  pick_idx_q;
	seg_t              pick_q;
	logic              prev_v_q, next_v_q;
	seg_t              prev_q, next_q;
	logic [CNT_W-1:0]  pos_q;
	logic              sw_down_q, sw_ins_q;
	logic [IDX_W-1:0]  sw_k_q;
	logic [CNT_W-1:0]  sw_left_q;
	seg_t              ins_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] grant_q;

	logic              we;
	logic [IDX_W-1:0]  waddr, raddr;
	seg_t              wdata, rd_seg;

	fpsa_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_seg)
	);

	// APB config port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_FIT_POLICY) ? {30'd0, policy_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 2'd0;
		end else if (psel && penable && pwrite) begin
			policy_q <= pwdata[1:0];
		end
	end

	// Request-side arithmetic
	logic [END_W-1:0] in_end, req_end, prev_end;
	assign in_end   = END_W'(release_start) + END_W'(req_length);
	assign req_end  = END_W'(rs_q) + END_W'(len_q);
	assign prev_end = END_W'(prev_q.start) + END_W'(prev_q.len);

	// Scan evaluation of the entry returned by the RAM
	logic fits, take;
	always_comb begin
		fits = rd_seg.len >= len_q;
		take = 1'b0;
		if (fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (policy_q == POL_BEST && rd_seg.len < pick_q.len) begin
				take = 1'b1;
			end else if (policy_q == POL_WORST && rd_seg.len > pick_q.len) begin
				take = 1'b1;
			end
		end
	end

	// Decision made once the scan is over
	logic [1:0]        ap_status;
	logic [ADDR_W-1:0] ap_grant;
	logic              ap_we, ap_sweep, ap_down;
	logic [IDX_W-1:0]  ap_waddr, ap_k;
	seg_t              ap_wdata;
	logic [CNT_W-1:0]  ap_left;
	logic [LEN_W-1:0]  a_rem;
	logic              ovl, jp, jn;
	always_comb begin
		ap_status = STAT_OK;
		ap_grant  = '0;
		ap_we     = 1'b0;
		ap_waddr  = '0;
		ap_wdata  = '0;
		ap_sweep  = 1'b0;
		ap_down   = 1'b1;
		ap_k      = '0;
		ap_left   = '0;
		a_rem     = pick_q.len - len_q;
		ovl = (prev_v_q && prev_end > END_W'(rs_q)) ||
			(next_v_q && END_W'(next_q.start) < req_end);
		jp  = prev_v_q && prev_end == END_W'(rs_q);
		jn  = next_v_q && END_W'(next_q.start) == req_end;
		if (act_q == ACT_ALLOC) begin
			if (!found_q) begin
				ap_status = STAT_NOFIT;
			end else begin
				ap_grant = pick_q.start;
				if (a_rem == '0) begin
					ap_sweep = 1'b1;
					ap_k     = pick_idx_q + 1'b1;
					ap_left  = count_q - CNT_W'(pick_idx_q) - 1'b1;
				end else begin
					ap_we          = 1'b1;
					ap_waddr       = pick_idx_q;
					ap_wdata.start = pick_q.start + len_q[ADDR_W-1:0];
					ap_wdata.len   = a_rem;
				end
			end
		end else if (ovl) begin
			ap_status = STAT_NOFIT;
		end else if (jp) begin
			ap_we          = 1'b1;
			ap_waddr       = IDX_W'(pos_q - 1'b1);
			ap_wdata.start = prev_q.start;
			ap_wdata.len   = prev_q.len + len_q + (jn ? next_q.len : '0);
			if (jn) begin
				ap_sweep = 1'b1;
				ap_k     = IDX_W'(pos_q + 1'b1);
				ap_left  = count_q - pos_q - 1'b1;
			end
		end else if (jn) begin
			ap_we          = 1'b1;
			ap_waddr       = IDX_W'(pos_q);
			ap_wdata.start = rs_q;
			ap_wdata.len   = next_q.len + len_q;
		end else if (count_q >= CNT_W'(MAX_SEGMENTS)) begin
			ap_status = STAT_FULL;
		end else begin
			ap_sweep = 1'b1;
			ap_down  = 1'b0;
			ap_k     = IDX_W'(count_q - 1'b1);
			ap_left  = count_q - pos_q;
		end
	end

	// RAM port muxing
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = sw_k_q;
		if (state_q == ST_SCAN) begin
			raddr = IDX_W'(scan_k_q);
		end
		case (state_q)
			ST_INIT: begin
				we          = 1'b1;
				wdata.len   = LEN_W'(POOL_UNITS);
			end
			ST_APPLY: begin
				we    = ap_we;
				waddr = ap_waddr;
				wdata = ap_wdata;
			end
			ST_SWEEP: begin
				if (v_s1) begin
					we    = 1'b1;
					waddr = sw_down_q ? idx_s1 - 1'b1 : idx_s1 + 1'b1;
					wdata = rd_seg;
				end else if (sw_left_q == '0 && sw_ins_q) begin
					we    = 1'b1;
					waddr = IDX_W'(pos_q);
					wdata = ins_q;
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			count_q  <= CNT_W'(1);
			v_s1     <= 1'b0;
			done_q   <= 1'b0;
			status_q <= STAT_OK;
			grant_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						act_q    <= action;
						len_q    <= req_length;
						rs_q     <= release_start;
						scan_k_q <= '0;
						found_q  <= 1'b0;
						prev_v_q <= 1'b0;
						next_v_q <= 1'b0;
						pos_q    <= '0;
						grant_q  <= '0;
						if (req_length == '0) begin
							done_q   <= 1'b1;
							status_q <= (action == ACT_ALLOC) ? STAT_NOFIT : STAT_OK;
						end else if (action == ACT_RELEASE &&
							in_end > END_W'(POOL_UNITS)) begin
							done_q   <= 1'b1;
							status_q <= STAT_NOFIT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, evaluate each in the cycle after its read
					v_s1   <= scan_k_q < count_q;
					idx_s1 <= IDX_W'(scan_k_q);
					if (scan_k_q < count_q) begin
						scan_k_q <= scan_k_q + 1'b1;
					end else if (!v_s1) begin
						state_q <= ST_APPLY;
					end
					if (v_s1) begin
						if (act_q == ACT_ALLOC) begin
							if (take) begin
								found_q    <= 1'b1;
								pick_idx_q <= idx_s1;
								pick_q     <= rd_seg;
							end
						end else if (rd_seg.start <= rs_q) begin
							prev_v_q <= 1'b1;
							prev_q   <= rd_seg;
							pos_q    <= CNT_W'(idx_s1) + 1'b1;
						end else if (!next_v_q) begin
							next_v_q <= 1'b1;
							next_q   <= rd_seg;
						end
					end
				end
				ST_APPLY: begin
					v_s1      <= 1'b0;
					grant_q   <= ap_grant;
					status_q  <= ap_status;
					sw_down_q <= ap_down;
					sw_ins_q  <= !ap_down;
					sw_k_q    <= ap_k;
					sw_left_q <= ap_left;
					ins_q     <= '{start: rs_q, len: len_q};
					if (ap_sweep) begin
						state_q <= ST_SWEEP;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_SWEEP: begin
					// move entries one slot down (remove) or up (insert)
					v_s1   <= sw_left_q != '0;
					idx_s1 <= sw_k_q;
					if (sw_left_q != '0) begin
						sw_left_q <= sw_left_q - 1'b1;
						sw_k_q    <= sw_down_q ? sw_k_q + 1'b1 : sw_k_q - 1'b1;
					end else if (!v_s1) begin
						count_q <= sw_ins_q ? count_q + 1'b1 : count_q - 1'b1;
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign grant_start = grant_q;

	// The table never holds more segments than it has rows
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEGMENTS))
		else $error("free segment count out of range");

	// A result is only issued on the way back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result issued while still working");

	// An insert sweep never moves a row from beyond the last valid row
	a_sweep_up: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && v_s1 && !sw_down_q) |-> CNT_W'(idx_s1) < count_q)
		else $error("insert sweep beyond table fill");

	// A grant is only reported with an ok status
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && grant_q != '0) |-> status_q == STAT_OK)
		else $error("grant with failing status");
endmodule
`default_nettype wire

@@ src/fpsa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
`default_nettype none
module fpsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench for fit_policy_segment_allocator: directed and random allocate and
// release words checked against a behavioral model of the free-segment table.
// Depends on fpsa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb;
	import fpsa_pkg::*;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] grant;
	} answer_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic action;
	logic [LEN_W-1:0] req_length;
	logic [ADDR_W-1:0] release_start;
	logic done;
	logic [1:0] status;
	logic [ADDR_W-1:0] grant_start;

	// Model of the free table
	int unsigned seg_start [MAX_SEGMENTS];
	int unsigned seg_len [MAX_SEGMENTS];
	int unsigned seg_count;
	logic [1:0] policy;

	answer_t answers_due[$];
	int errors;

	fit_policy_segment_allocator dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .action(action), .req_length(req_length),
		.release_start(release_start), .done(done), .status(status),
		.grant_start(grant_start)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	task automatic drop_seg(input int unsigned idx);
		for (int unsigned k = idx; k + 1 < seg_count; k++) begin
			seg_start[k] = seg_start[k + 1];
			seg_len[k] = seg_len[k + 1];
		end
		seg_count--;
		seg_start[seg_count] = 0;
		seg_len[seg_count] = 0;
	endtask

	task automatic model_alloc(input int unsigned len, output answer_t ans);
		bit found;
		int unsigned pick;
		found = 0;
		pick = 0;
		ans = '{status: STAT_NOFIT, grant: '0};
		if (len == 0)
			return;
		for (int unsigned k = 0; k < seg_count; k++) begin
			if (seg_len[k] < len)
				continue;
			if (!found) begin
				found = 1;
				pick = k;
				if (policy != POL_BEST && policy != POL_WORST)
					break;
			end else if (policy == POL_BEST && seg_len[k] < seg_len[pick]) begin
				pick = k;
			end else if (policy == POL_WORST && seg_len[k] > seg_len[pick]) begin
				pick = k;
			end
		end
		if (!found)
			return;
		ans.status = STAT_OK;
		ans.grant = seg_start[pick][ADDR_W-1:0];
		seg_start[pick] += len;
		seg_len[pick] -= len;
		if (seg_len[pick] == 0)
			drop_seg(pick);
	endtask

	task automatic model_release(input int unsigned st, input int unsigned len,
			output answer_t ans);
		int unsigned pos, stop;
		bit join_lo, join_hi;
		ans = '{status: STAT_OK, grant: '0};
		if (len == 0)
			return;
		stop = st + len;
		if (stop > POOL_UNITS) begin
			ans.status = STAT_NOFIT;
			return;
		end
		pos = 0;
		while (pos < seg_count && seg_start[pos] <= st)
			pos++;
		if ((pos > 0 && seg_start[pos-1] + seg_len[pos-1] > st) ||
				(pos < seg_count && seg_start[pos] < stop)) begin
			ans.status = STAT_NOFIT;
			return;
		end
		join_lo = pos > 0 && seg_start[pos-1] + seg_len[pos-1] == st;
		join_hi = pos < seg_count && seg_start[pos] == stop;
		if (join_lo && join_hi) begin
			seg_len[pos-1] += len + seg_len[pos];
			drop_seg(pos);
		end else if (join_lo) begin
			seg_len[pos-1] += len;
		end else if (join_hi) begin
			seg_start[pos] = st;
			seg_len[pos] += len;
		end else begin
			if (seg_count >= MAX_SEGMENTS) begin
				ans.status = STAT_FULL;
				return;
			end
			for (int unsigned k = seg_count; k > pos; k--) begin
				seg_start[k] = seg_start[k-1];
				seg_len[k] = seg_len[k-1];
			end
			seg_start[pos] = st;
			seg_len[pos] = len;
			seg_count++;
		end
	endtask

	// Send one request word after a random gap; start stays high after the
	// accepting edge until a later gap or drain takes it down
	task automatic send_word(input logic act, input int unsigned len, input int unsigned st);
		answer_t ans;
		int unsigned gap;
		gap = $urandom_range(0, 5);
		if (gap != 0)
			start <= 1'b0;
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		action <= act;
		req_length <= len[LEN_W-1:0];
		release_start <= st[ADDR_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act == ACT_ALLOC)
			model_alloc(len[LEN_W-1:0], ans);
		else
			model_release(st[ADDR_W-1:0], len[LEN_W-1:0], ans);
		answers_due.push_back(ans);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_SEGMENTS + 8) @(posedge clk);
	endtask

	task automatic write_policy(input logic [1:0] val);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_FIT_POLICY;
		pwdata <= {30'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		policy = val;
	endtask

	// Result checker
	always @(posedge clk) begin
		answer_t want;
		if (done) begin
			if (answers_due.size() == 0) begin
				$error("unexpected result word status=%0d grant=%0d", status, grant_start);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					errors++;
				end
				if (grant_start !== want.grant) begin
					$error("grant_start expected %0d actual %0d", want.grant, grant_start);
					errors++;
				end
			end
		end
	end

	// Corner cases: zero lengths, whole pool, out of pool, overlap, table full
	task automatic test_directed();
		send_word(ACT_ALLOC, 0, 0);
		send_word(ACT_RELEASE, 0, 1023);
		send_word(ACT_ALLOC, 2047, 0);
		send_word(ACT_ALLOC, 1024, 0);
		send_word(ACT_ALLOC, 1, 0);
		send_word(ACT_RELEASE, 1024, 0);
		send_word(ACT_RELEASE, 2, 1023);
		send_word(ACT_RELEASE, 1, 5);
		send_word(ACT_ALLOC, 1024, 0);
		for (int i = 0; i < 17; i++)
			send_word(ACT_RELEASE, 1, 2 * i);
		send_word(ACT_RELEASE, 1, 1);
		send_word(ACT_RELEASE, 1, 1022);
	endtask

	// A noise release never overlaps free space, so it freed held units; forget
	// tracking to avoid double release
	task automatic drain_held(ref int unsigned hs[$], ref int unsigned hl[$]);
		hs.delete();
		hl.delete();
	endtask

	// Random requests: allocations, releases of allocated ranges so the table fragments, and noise releases
	task automatic test_random(input int n);
		int unsigned held_st[$], held_len[$];
		int unsigned idx, len, st;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
						: $urandom_range(1, 64);
					send_word(ACT_ALLOC, len, $urandom_range(0, 1023));
					if (answers_due[$].status == STAT_OK) begin
						held_st.push_back(answers_due[$].grant);
						held_len.push_back(len);
					end
				end
				4, 5, 6, 7: begin
					if (held_st.size() != 0) begin
						idx = $urandom_range(0, held_st.size() - 1);
						st = held_st[idx];
						len = held_len[idx];
						// release a piece, keep the remainder
						if (len > 1 && $urandom_range(0, 2) == 0) begin
							held_len[idx] = len / 2;
							held_st[idx] = st + len - len / 2;
							len = len - len / 2;
						end else begin
							held_st.delete(idx);
							held_len.delete(idx);
						end
						send_word(ACT_RELEASE, len, st);
						if (answers_due[$].status != STAT_OK) begin
							held_st.push_back(st);
							held_len.push_back(len);
						end
					end else
						send_word(ACT_ALLOC, $urandom_range(1, 300), 0);
				end
				default: begin
					// noise; tracking stays right since model decides and held ranges
					// are never free, so a success here frees held units and tracking is dropped
					send_word(ACT_RELEASE, $urandom_range(0, 2047), $urandom_range(0, 1023));
					if (answers_due[$].status == STAT_OK)
						drain_held(held_st, held_len);
				end
			endcase
			if (i == n / 2)
				drain();
		end
	endtask

	initial begin
		errors = 0;
		seg_start = '{default: 0};
		seg_len = '{default: 0};
		seg_start[0] = 0;
		seg_len[0] = POOL_UNITS;
		seg_count = 1;
		policy = 2'd0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; action = 1'b0; req_length = '0; release_start = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_policy(POL_BEST);
		test_random(450);
		write_policy(POL_WORST);
		test_random(450);
		write_policy(2'd3);
		test_random(400);
		write_policy(2'd0);
		test_random(420);
		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

@@ filelist.f @@
src/fpsa_pkg.sv
src/fpsa_ram.sv
src/fit_policy_segment_allocator.sv
bench/tb.sv
